// ----- rtl/core/tbt_pkg.sv -----
// tone buzzer timer package: word types, command codes and fixed sizes
package tbt_pkg;

    // fixed field and state widths
    localparam int COUNT_BITS    = 16;
    localparam int DURATION_BITS = 16;
    localparam int CLOCK_BITS    = 26;
    localparam int HALF_BITS     = CLOCK_BITS - 1;
    localparam int PRE_SHIFT     = 4;
    localparam int DIV_STEPS     = CLOCK_BITS;
    localparam int STEP_BITS     = $clog2(DIV_STEPS);

    localparam logic [CLOCK_BITS-1:0] CLOCK_RESET = 26'd3686400;

    // prescaler selections and their terminal counts
    localparam logic [1:0] PRE_DIV1   = 2'd0;
    localparam logic [1:0] PRE_DIV16  = 2'd1;
    localparam logic [1:0] PRE_DIV256 = 2'd2;
    localparam logic [7:0] PRE_LIMIT_DIV1   = 8'd0;
    localparam logic [7:0] PRE_LIMIT_DIV16  = 8'd15;
    localparam logic [7:0] PRE_LIMIT_DIV256 = 8'd255;

    // command codes
    localparam logic [1:0] CMD_CLK_TICK = 2'd0;
    localparam logic [1:0] CMD_SYS_TICK = 2'd1;
    localparam logic [1:0] CMD_TONE     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]               command;
        logic [COUNT_BITS-1:0]    tone_hz;
        logic [DURATION_BITS-1:0] duration_ticks;
    } t_in_word;

    typedef struct packed {
        logic                  pin_level;
        logic                  is_sounding;
        logic                  is_enabled;
        logic [COUNT_BITS-1:0] reload_out;
        logic [1:0]            prescale_out;
    } t_out_word;

endpackage

// ----- rtl/core/tone_buzzer_timer_unit.sv -----
// tone buzzer timer: prescaled half-period counter with serial frequency divider
//
// Input channel: i_in_valid / o_in_stall carry one command word (timer clock
// tick, system tick or tone request). Output channel: o_out_valid / i_out_stall
// return one status word per command: pin level, timed flag, run flag, reload
// value and prescaler in use, all as left by that command.
// Timer ticks, system ticks and stop requests (tone 0 Hz) are handled in the
// cycle they are accepted; the status word appears on the next cycle and a new
// word can be taken every cycle while the status output is not stalled.
// A tone request with a nonzero frequency runs a restoring divider, one
// quotient bit per cycle, then a finish state sets the reload and prescaler
// and loads the status word; o_in_stall stays high until the block is back
// in idle, so no new word is taken while the divider runs.
// The user must write the clock rate register (i_cfg_we / i_cfg_data) only while
// idle; the block does not enforce it. A stalled status word holds; new words are
// refused while it cannot move on. Synchronous reset: timer stopped, pin low,
// clock rate back to 3686400 Hz, output empty.
module tone_buzzer_timer_unit
    import tbt_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [25:0]     i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in_word        i_in_word,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out_word       o_out_word
);

    t_state r_state, n_state;

    logic [CLOCK_BITS-1:0]    r_clk_hz;
    logic                     r_run, n_run;
    logic                     r_pin, n_pin;
    logic                     r_timed, n_timed;
    logic [DURATION_BITS-1:0] r_ticks, n_ticks;
    logic [COUNT_BITS-1:0]    r_reload, n_reload;
    logic [COUNT_BITS-1:0]    r_down, n_down;
    logic [1:0]               r_sel, n_sel;
    logic [7:0]               r_pcnt, n_pcnt;

    // divider registers
    logic [COUNT_BITS-1:0]    r_div;
    logic [COUNT_BITS-1:0]    r_rem;
    logic [CLOCK_BITS-1:0]    r_quo;
    logic [STEP_BITS-1:0]     r_step;
    logic [DURATION_BITS-1:0] r_dur;

    logic                     r_out_valid;
    t_out_word                r_out_word;

    logic in_accept, out_free, start_req;
    logic s_div_start, s_div_step, s_finish;
    logic out_load;

    logic [COUNT_BITS:0]      s_trial, s_diff;
    logic                     s_ge;
    logic [HALF_BITS-1:0]     s_half, s_h1, s_h2;
    logic [1:0]               s_sel;
    logic [7:0]               s_limit;
    logic [DURATION_BITS-1:0] s_ticks_dec;

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign start_req  = in_accept && (i_in_word.command == CMD_TONE)
                        && (i_in_word.tone_hz != '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_req) n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (r_step == STEP_BITS'(DIV_STEPS - 1)) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_div_start = 1'b0;
        s_div_step  = 1'b0;
        s_finish    = 1'b0;
        unique case (r_state)
            ST_IDLE:   s_div_start = start_req;
            ST_DIVIDE: s_div_step  = 1'b1;
            ST_FINISH: s_finish    = out_free;
            default: ;
        endcase
    end

    assign out_load = (in_accept && !start_req) || s_finish;

    // shared subtract and compare for the restoring divider
    assign s_trial = {r_rem, r_quo[CLOCK_BITS-1]};
    assign s_diff  = s_trial - {1'b0, r_div};
    assign s_ge    = (s_trial >= {1'b0, r_div});

    // half-period and prescaler choice
    always_comb begin
        s_half = r_quo[CLOCK_BITS-1:1];
        s_h1   = s_half;
        s_sel  = PRE_DIV1;
        if (s_half[HALF_BITS-1:COUNT_BITS] != '0) begin
            s_h1  = s_half >> PRE_SHIFT;
            s_sel = PRE_DIV16;
        end
        s_h2 = s_h1;
        if (s_h1[HALF_BITS-1:COUNT_BITS] != '0) begin
            s_h2  = s_h1 >> PRE_SHIFT;
            s_sel = PRE_DIV256;
        end
    end

    // prescaler terminal count
    always_comb begin
        case (r_sel)
            PRE_DIV1:  s_limit = PRE_LIMIT_DIV1;
            PRE_DIV16: s_limit = PRE_LIMIT_DIV16;
            default:   s_limit = PRE_LIMIT_DIV256;
        endcase
    end

    assign s_ticks_dec = r_ticks - DURATION_BITS'(1);

    // timer state update
    always_comb begin
        n_run    = r_run;
        n_pin    = r_pin;
        n_timed  = r_timed;
        n_ticks  = r_ticks;
        n_reload = r_reload;
        n_down   = r_down;
        n_sel    = r_sel;
        n_pcnt   = r_pcnt;
        if (in_accept && !start_req) begin
            case (i_in_word.command)
                CMD_CLK_TICK: begin
                    if (r_run) begin
                        if (r_pcnt < s_limit) begin
                            n_pcnt = r_pcnt + 8'd1;
                        end else begin
                            n_pcnt = '0;
                            if (r_down == '0) begin
                                n_pin  = ~r_pin;
                                n_down = r_reload;
                            end else begin
                                n_down = r_down - COUNT_BITS'(1);
                            end
                        end
                    end
                end
                CMD_SYS_TICK: begin
                    if (r_timed) begin
                        n_ticks = s_ticks_dec;
                        if (s_ticks_dec == '0) begin
                            n_run   = 1'b0;
                            n_pin   = 1'b0;
                            n_timed = 1'b0;
                        end
                    end
                end
                CMD_TONE: begin
                    // zero frequency: stop at once
                    n_run   = 1'b0;
                    n_pin   = 1'b0;
                    n_timed = 1'b0;
                    n_ticks = '0;
                end
                default: ;
            endcase
        end else if (s_finish) begin
            n_reload = s_h2[COUNT_BITS-1:0];
            n_sel    = s_sel;
            n_down   = s_h2[COUNT_BITS-1:0];
            n_pcnt   = '0;
            n_pin    = 1'b0;
            n_run    = 1'b1;
            if ((r_dur != '0) && !r_timed) begin
                n_ticks = r_dur;
                n_timed = 1'b1;
            end
        end
    end

    // control and timer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clk_hz    <= CLOCK_RESET;
            r_run       <= 1'b0;
            r_pin       <= 1'b0;
            r_timed     <= 1'b0;
            r_ticks     <= '0;
            r_reload    <= '0;
            r_down      <= '0;
            r_sel       <= PRE_DIV1;
            r_pcnt      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_run    <= n_run;
            r_pin    <= n_pin;
            r_timed  <= n_timed;
            r_ticks  <= n_ticks;
            r_reload <= n_reload;
            r_down   <= n_down;
            r_sel    <= n_sel;
            r_pcnt   <= n_pcnt;
            if (i_cfg_we) r_clk_hz <= i_cfg_data;
            if (s_div_start) begin
                r_step <= '0;
            end else if (s_div_step) begin
                r_step <= r_step + STEP_BITS'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider datapath, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (s_div_start) begin
            r_div <= i_in_word.tone_hz;
            r_dur <= i_in_word.duration_ticks;
            r_rem <= '0;
            r_quo <= r_clk_hz;
        end else if (s_div_step) begin
            r_rem <= s_ge ? s_diff[COUNT_BITS-1:0] : s_trial[COUNT_BITS-1:0];
            r_quo <= {r_quo[CLOCK_BITS-2:0], s_ge};
        end
    end

    // status word register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word.pin_level    <= n_pin;
            r_out_word.is_sounding  <= n_timed;
            r_out_word.is_enabled   <= n_run;
            r_out_word.reload_out   <= n_reload;
            r_out_word.prescale_out <= n_sel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- rtl/core/tbt_checker.sv -----
// port-level checks for the tone buzzer timer, bound to the top level
module tbt_checker
    import tbt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

    // a tone request with a frequency starts the divider, which blocks input
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.command == CMD_TONE
         && i_in_word.tone_hz != '0) |=> o_in_stall)
        else $error("input not stalled while dividing");

    // a stop request gives a silent, stopped status on the next cycle
    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.command == CMD_TONE
         && i_in_word.tone_hz == '0)
        |=> (o_out_valid && !o_out_word.pin_level && !o_out_word.is_enabled
             && !o_out_word.is_sounding))
        else $error("stop request did not silence the buzzer");

    // a pending timed tone always has the timer running
    a_timed_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.is_sounding) |-> o_out_word.is_enabled)
        else $error("timed tone pending with timer stopped");

endmodule

bind tone_buzzer_timer_unit tbt_checker u_tbt_checker (.*);

// ----- verif/testbench.sv -----
// self-checking tone buzzer timer bench: directed and random commands against a live timer model
module testbench;
    import tbt_pkg::*;

    // command code the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned PHASE_WORDS  = 140;
    localparam int unsigned NUM_RATES    = 6;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CLOCK_BITS-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;

    // command words waiting to go in, status words waiting to come out
    t_in_word  pending_q[$];
    t_out_word status_q[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned words_planned  = 0;
    int unsigned words_in       = 0;
    int unsigned words_checked  = 0;
    int unsigned toggles        = 0;
    int unsigned expiries       = 0;
    int unsigned errors         = 0;
    int unsigned cycles         = 0;

    // timer model state
    logic                     run_on    = 1'b0;
    logic                     pin_hi    = 1'b0;
    logic                     timed_on  = 1'b0;
    logic [DURATION_BITS-1:0] ticks_rem = '0;
    logic [COUNT_BITS-1:0]    reload_q  = '0;
    logic [COUNT_BITS-1:0]    count_q   = '0;
    logic [1:0]               pre_sel   = PRE_DIV1;
    logic [7:0]               pre_cnt   = '0;
    logic [CLOCK_BITS-1:0]    clk_hz    = CLOCK_RESET;

    tone_buzzer_timer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // silence the buzzer and drop any pending expiry
    function automatic void silence_tone();
        run_on    = 1'b0;
        pin_hi    = 1'b0;
        timed_on  = 1'b0;
        ticks_rem = '0;
    endfunction

    // advance the timer model by one command word, return the status it leaves
    function automatic t_out_word step_timer(input t_in_word w);
        logic [CLOCK_BITS-1:0] half;
        logic [1:0]            sel;
        logic [7:0]            pre_top;
        t_out_word             st;
        case (w.command)
            CMD_CLK_TICK: begin
                if (run_on) begin
                    case (pre_sel)
                        PRE_DIV1:  pre_top = PRE_LIMIT_DIV1;
                        PRE_DIV16: pre_top = PRE_LIMIT_DIV16;
                        default:   pre_top = PRE_LIMIT_DIV256;
                    endcase
                    if (pre_cnt < pre_top) begin
                        pre_cnt = pre_cnt + 8'd1;
                    end else begin
                        pre_cnt = '0;
                        if (count_q == '0) begin
                            pin_hi  = ~pin_hi;
                            count_q = reload_q;
                            toggles++;
                        end else begin
                            count_q = count_q - COUNT_BITS'(1);
                        end
                    end
                end
            end
            CMD_SYS_TICK: begin
                if (timed_on) begin
                    ticks_rem = ticks_rem - DURATION_BITS'(1);
                    if (ticks_rem == '0) begin
                        silence_tone();
                        expiries++;
                    end
                end
            end
            CMD_TONE: begin
                if (w.tone_hz != '0) begin
                    // half-period, stepped down through the prescaler until it fits
                    half = clk_hz / CLOCK_BITS'(w.tone_hz);
                    half = half >> 1;
                    sel  = PRE_DIV1;
                    if ((half >> COUNT_BITS) != '0) begin
                        half = half >> PRE_SHIFT;
                        sel  = PRE_DIV16;
                    end
                    if ((half >> COUNT_BITS) != '0) begin
                        half = half >> PRE_SHIFT;
                        sel  = PRE_DIV256;
                    end
                    reload_q = half[COUNT_BITS-1:0];
                    pre_sel  = sel;
                    count_q  = reload_q;
                    pre_cnt  = '0;
                    pin_hi   = 1'b0;
                    run_on   = 1'b1;
                    // an expiry already pending keeps its own count
                    if (w.duration_ticks != '0 && !timed_on) begin
                        ticks_rem = w.duration_ticks;
                        timed_on  = 1'b1;
                    end
                end else begin
                    silence_tone();
                end
            end
            default: begin
            end
        endcase
        st.pin_level    = pin_hi;
        st.is_sounding  = timed_on;
        st.is_enabled   = run_on;
        st.reload_out   = reload_q;
        st.prescale_out = pre_sel;
        return st;
    endfunction

    task automatic report_error(input string msg);
        if (errors < 40) begin
            $display("error at cycle %0d: %s", cycles, msg);
        end
        errors++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_error($sformatf("status word %0d %s got %0h want %0h",
                                   words_checked, name, got, want));
        end
    endtask

    task automatic queue_word(input logic [1:0] cmd, input logic [15:0] hz,
                              input logic [15:0] dur);
        t_in_word w;
        w.command        = cmd;
        w.tone_hz        = hz;
        w.duration_ticks = dur;
        pending_q.push_back(w);
        if (cmd != CMD_UNUSED) begin
            words_planned++;
        end
    endtask

    // tone requests each followed by a run of ticks, with some noise mixed in
    task automatic queue_phase(input int unsigned stop_at);
        int unsigned tgt;
        int unsigned roll;
        int unsigned body;
        logic [15:0] dur;
        // lowest frequency first: deepest prescaler, or truncation at fast clocks
        queue_word(CMD_TONE, 16'd1, 16'd0);
        while (words_planned < stop_at) begin
            if ($urandom_range(99) < 60) begin
                // aim for a short half-period so the pin toggles within the run
                tgt = 32'(clk_hz) / (2 * $urandom_range(16, 1));
                if (tgt == 0) begin
                    tgt = 1;
                end
                if (tgt > 65535) begin
                    tgt = $urandom_range(65535, 32768);
                end
            end else begin
                tgt = $urandom_range(65535, 0);
            end
            roll = $urandom_range(99);
            if (roll < 40) begin
                dur = '0;
            end else if (roll < 80) begin
                dur = 16'($urandom_range(8, 1));
            end else begin
                dur = 16'($urandom);
            end
            queue_word(CMD_TONE, tgt[15:0], dur);
            body = $urandom_range(80, 10);
            repeat (body) begin
                roll = $urandom_range(99);
                if (roll < 84) begin
                    queue_word(CMD_CLK_TICK, 16'($urandom), 16'($urandom));
                end else if (roll < 94) begin
                    queue_word(CMD_SYS_TICK, 16'($urandom), 16'($urandom));
                end else if (roll < 96) begin
                    queue_word(CMD_UNUSED, 16'($urandom), 16'($urandom));
                end else if (roll < 98) begin
                    queue_word(CMD_TONE, 16'd0, 16'($urandom));
                end else begin
                    queue_word(CMD_TONE, 16'($urandom), 16'($urandom));
                end
            end
        end
    endtask

    task automatic write_clock(input logic [CLOCK_BITS-1:0] hz);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= hz;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        clk_hz = hz;
    endtask

    // block idle: nothing queued, nothing offered, no status outstanding
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_q.size() != 0 || i_in_valid || status_q.size() != 0);
    endtask

    // driver: offer queued words, predict each one as it is taken
    always @(posedge i_clk) begin : drive_p
        logic moved;
        moved = i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (moved) begin
                status_q.push_back(step_timer(i_in_word));
                words_in++;
            end
            if (!i_in_valid || moved) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_word  <= pending_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each status word taken with the oldest prediction
    always @(posedge i_clk) begin : watch_p
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                report_error($sformatf("status word %0h with nothing expected", o_out_word));
            end else begin
                want = status_q.pop_front();
                check_field("pin_level", 32'(o_out_word.pin_level), 32'(want.pin_level));
                check_field("is_sounding", 32'(o_out_word.is_sounding),
                            32'(want.is_sounding));
                check_field("is_enabled", 32'(o_out_word.is_enabled), 32'(want.is_enabled));
                check_field("reload_out", 32'(o_out_word.reload_out), 32'(want.reload_out));
                check_field("prescale_out", 32'(o_out_word.prescale_out),
                            32'(want.prescale_out));
            end
            words_checked++;
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run stopped at cycle limit %0d", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // sequencing: reset, directed words, then one random phase per clock rate
    initial begin : run_p
        logic [CLOCK_BITS-1:0] rates [NUM_RATES];
        int unsigned           p;
        rates[0] = 26'd1;
        rates[1] = 26'h3FFFFFF;
        rates[2] = 26'd0;
        rates[3] = CLOCK_RESET;
        rates[4] = CLOCK_BITS'($urandom);
        rates[5] = 26'd1000000;
        send_idle_pct  = 23;
        recv_stall_pct = 76;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words at the reset clock rate
        queue_word(CMD_CLK_TICK, 16'hFFFF, 16'hFFFF);   // tick while stopped
        queue_word(CMD_SYS_TICK, 16'hFFFF, 16'hFFFF);   // system tick, nothing pending
        queue_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        queue_word(CMD_TONE, 16'hFFFF, 16'd3);          // highest frequency, timed
        queue_word(CMD_CLK_TICK, 16'h0000, 16'h0000);
        queue_word(CMD_CLK_TICK, 16'h0000, 16'h0000);
        queue_word(CMD_TONE, 16'd28, 16'd5);            // just over 16 bits: divide 16
        queue_word(CMD_SYS_TICK, 16'h0000, 16'h0000);
        queue_word(CMD_SYS_TICK, 16'h0000, 16'h0000);
        queue_word(CMD_SYS_TICK, 16'h0000, 16'h0000);   // expiry
        queue_word(CMD_SYS_TICK, 16'h0000, 16'h0000);
        queue_word(CMD_TONE, 16'd29, 16'd0);            // just fits: divide 1
        queue_word(CMD_TONE, 16'd1, 16'd0);             // lowest frequency: divide 256
        queue_word(CMD_CLK_TICK, 16'h0000, 16'h0000);
        queue_word(CMD_CLK_TICK, 16'h0000, 16'h0000);
        queue_word(CMD_TONE, 16'd0, 16'd7);             // stop while untimed
        queue_word(CMD_CLK_TICK, 16'h0000, 16'h0000);
        queue_word(CMD_TONE, 16'd2, 16'hFFFF);          // longest duration
        queue_word(CMD_UNUSED, 16'h0000, 16'h0000);
        queue_word(CMD_TONE, 16'd0, 16'd0);             // stop cancels the expiry
        queue_word(CMD_SYS_TICK, 16'h0000, 16'h0000);
        queue_word(CMD_TONE, 16'd57600, 16'd1);
        queue_word(CMD_SYS_TICK, 16'h0000, 16'h0000);
        wait_idle();

        for (p = 0; p < NUM_RATES; p++) begin
            if (p < 2) begin
                send_idle_pct  = 23;
                recv_stall_pct = 76;
            end else if (p < 4) begin
                send_idle_pct  = 76;
                recv_stall_pct = 23;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_clock(rates[p]);
            @(negedge i_clk);
            queue_phase(words_planned + PHASE_WORDS);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (status_q.size() != 0) begin
            report_error($sformatf("%0d status words never arrived", status_q.size()));
        end
        $display("covered %0d command words over %0d clock rates, %0d status words checked",
                 words_in, NUM_RATES + 1, words_checked);
        $display("pin toggles %0d, timed expiries %0d, errors %0d", toggles, expiries, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
